### src/mexp_pkg.sv
// Shared definitions for the modular exponentiation block.
// Holds the stream width, the register indexes and the multiplier handshake structs.
// No dependencies.
package mexp_pkg;

  localparam int DATA_W    = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  typedef struct packed {
    logic start;
  } mm_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_sts_t;

endpackage

### src/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle, MSB first.
// Computes op_a * op_b mod modulus for op_a, op_b below modulus (op_a may equal one).
// Depends on mexp_pkg for the control and status structs.
module mexp_mulmod #(
  parameter int WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mexp_pkg::mm_ctl_t    ctl,
  input  logic [WIDTH-1:0]     op_a,
  input  logic [WIDTH-1:0]     op_b,
  input  logic [WIDTH-1:0]     modulus,
  output mexp_pkg::mm_sts_t    sts,
  output logic [WIDTH-1:0]     product
);
  import mexp_pkg::*;

  localparam int CNT_W = $clog2(WIDTH + 1);
  localparam int SW    = WIDTH + 3;

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic [SW-1:0] sum;
  logic [SW-1:0] diff1;
  logic [SW-1:0] diff2;
  logic [WIDTH-1:0] step_val;

  // The sum 2*acc + a stays below three times the modulus, so at most two
  // subtractions of the modulus bring it back into range.
  always_comb begin
    sum   = {2'b00, acc_r, 1'b0} + (b_r[WIDTH-1] ? SW'(a_r) : SW'(0));
    diff1 = sum - SW'(modulus);
    diff2 = sum - {2'b00, modulus, 1'b0};
    if (!diff2[SW-1]) begin
      step_val = diff2[WIDTH-1:0];
    end else if (!diff1[SW-1]) begin
      step_val = diff1[WIDTH-1:0];
    end else begin
      step_val = sum[WIDTH-1:0];
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start && cnt_r == '0) begin
      acc_nxt = '0;
      a_nxt   = op_a;
      b_nxt   = op_b;
      cnt_nxt = CNT_W'(WIDTH);
    end else if (cnt_r != '0) begin
      acc_nxt  = step_val;
      b_nxt    = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign product  = acc_r;

endmodule

### src/modular_exponentiation.sv
// Modular exponentiation: message^exponent mod modulus, right-to-left square-and-multiply.
// The base reduction and every multiply and square run on the single shared bit-serial modular multiplier.
// One transaction is in work at a time; in_tready is low until its result is registered.
// Reset (synchronous, rst_n low) clears the controller and sets exponent 0, modulus 1.
// Depends on mexp_pkg and mexp_mulmod.
module modular_exponentiation #(
  parameter int WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mexp_pkg::DATA_W-1:0]       in_tdata,   // [63:0] message_word
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mexp_pkg::DATA_W-1:0]       out_tdata,  // [63:0] power_result
  input  logic                              cfg_wen,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mexp_pkg::DATA_W-1:0]       cfg_wdata
);
  import mexp_pkg::*;

  localparam int BCNT_W = $clog2(WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_STEP,
    S_MUL_R,
    S_SQR,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [WIDTH-1:0]  exp_r, exp_nxt;
  logic [WIDTH-1:0]  mod_r, mod_nxt;
  logic [WIDTH-1:0]  e_sh_r, e_sh_nxt;
  logic [BCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [WIDTH-1:0]  base_r, base_nxt;
  logic [WIDTH-1:0]  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0]  out_data_r, out_data_nxt;

  mm_ctl_t           mul_ctl;
  mm_sts_t           mul_sts;
  logic [WIDTH-1:0]  mul_a;
  logic [WIDTH-1:0]  mul_b;
  logic [WIDTH-1:0]  mul_p;
  logic              in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // The base is reduced as 1 * message mod m on the same multiplier.
  assign mul_a = (state_r == S_IDLE) ? WIDTH'(1) :
                 (state_r == S_STEP && e_sh_r[0]) ? res_r : base_r;
  assign mul_b = (state_r == S_IDLE) ? in_tdata[WIDTH-1:0] : base_r;

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (mod_r),
    .sts     (mul_sts),
    .product (mul_p)
  );

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    e_sh_nxt      = e_sh_r;
    bit_cnt_nxt   = bit_cnt_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_ctl.start = 1'b0;

    if (cfg_wen) begin
      unique case (cfg_index)
        REG_EXPONENT: exp_nxt = cfg_wdata[WIDTH-1:0];
        REG_MODULUS:  mod_nxt = cfg_wdata[WIDTH-1:0];
        default: ;
      endcase
    end

    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (mod_r == '0) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            mul_ctl.start = 1'b1;
            res_nxt       = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);
            e_sh_nxt      = exp_r;
            bit_cnt_nxt   = BCNT_W'(WIDTH);
            state_nxt     = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mul_sts.done) begin
          base_nxt  = mul_p;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (bit_cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          mul_ctl.start = 1'b1;
          state_nxt     = e_sh_r[0] ? S_MUL_R : S_SQR;
        end
      end
      S_MUL_R: begin
        if (mul_sts.done) begin
          res_nxt       = mul_p;
          mul_ctl.start = 1'b1;
          state_nxt     = S_SQR;
        end
      end
      S_SQR: begin
        if (mul_sts.done) begin
          base_nxt    = mul_p;
          e_sh_nxt    = e_sh_r >> 1;
          bit_cnt_nxt = bit_cnt_r - BCNT_W'(1);
          state_nxt   = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= '0;
      mod_r       <= WIDTH'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_sh_r     <= e_sh_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    base_r     <= base_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

`ifndef SYNTHESIS
  // A delivered result is always reduced below a non-zero modulus.
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (mod_r != '0) |-> (out_data_r < mod_r))
    else $error("result not below modulus");

  // The multiplier is never left running while a new transaction can be taken.
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mul_sts.busy)
    else $error("multiplier busy while idle");

  // A zero modulus skips the arithmetic and goes straight to delivery.
  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (mod_r == '0) |=> (state_r == S_DONE) && (res_r == '0))
    else $error("zero modulus not short-circuited");

  // A multiplication only finishes while the controller waits for one.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == S_REDUCE) || (state_r == S_MUL_R) || (state_r == S_SQR))
    else $error("unexpected multiplier completion");
`endif

endmodule
